// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array list package
// Shared types and constants for the positional array list block.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

   localparam int DEPTH_DEF   = 64;
   localparam int FUNC_W      = 2;
   localparam int POS_W       = 7;
   localparam int VALUE_W     = 8;
   localparam int COUNT_W     = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_LOCATE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               done;
      logic               ok;
      logic [VALUE_W-1:0] data_out;
      logic [POS_W-1:0]   found_at;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/positional_array_list.sv =====
// A failed request, or a locate on an empty list, goes straight to the done state; an append at
// the tail goes straight to the put step; a read fetches one entry, insert and delete walk the
// entries moved, and locate walks up to the first match, or the whole list if it is absent.
// Throughput: one request at a time, set by the single read and write port of the element store,
// which moves one entry per cycle.
// Reset clears the list length and all handshake state; no clearing pass.
// ----------------------------------------------------------------------------
// Positional array list
// Ordered byte list with positional insert, delete, read and value locate.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list import pal_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FUNC_W-1:0]  req_func,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic      [VALUE_W-1:0] rsp_data_out,
   output logic      [POS_W-1:0]   rsp_found_at,
   output logic      [COUNT_W-1:0] rsp_count,
   output logic                    rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);

   result_type         result;
   logic               rsp_free;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   pal_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_position(req_position),
      .req_value   (req_value),
      .rsp_free    (rsp_free),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   pal_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // The output register frees the sequencer to take the next transaction
   // while a finished result waits to be taken.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ff.ok;
   assign rsp_data_out = rsp_ff.data_out;
   assign rsp_found_at = rsp_ff.found_at;
   assign rsp_count    = rsp_ff.count;
   assign rsp_is_empty = rsp_ff.is_empty;

endmodule

`default_nettype wire

// ===== rtl/pal_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional array list sequencer
// Validates a request, then walks the element store one entry per cycle to
// shift, fetch or search, and finally hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl import pal_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [FUNC_W-1:0]        req_func,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic [VALUE_W-1:0]       req_value,
   input  wire logic                     rsp_free,
   output result_type                    result,
   output logic                          ram_wr_en,
   output logic      [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic      [VALUE_W-1:0]       ram_wr_data,
   output logic                          ram_rd_en,
   output logic      [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  wire logic [VALUE_W-1:0]       ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

   state_type          state_ff, state_in;
   func_type           op_ff, op_in;
   logic [AW-1:0]      pos_idx_ff, pos_idx_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      end_ff, end_in;
   logic               iss_ff, iss_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      padr_ff, padr_in;
   logic               ok_ff, ok_in;
   logic [VALUE_W-1:0] data_ff, data_in;
   logic [POS_W-1:0]   found_ff, found_in;

   logic [CW-1:0]      pos_w;
   logic [CW-1:0]      len_w;
   logic               ins_ok;
   logic               acc_ok;

   assign pos_w  = CW'(req_position);
   assign len_w  = CW'(len_ff);
   assign ins_ok = (pos_w != '0) && (pos_w <= len_w + CW'(1)) && (len_w < CW'(DEPTH));
   assign acc_ok = (pos_w != '0) && (pos_w <= len_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         iss_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         iss_ff   <= iss_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_idx_ff <= pos_idx_in;
      val_ff     <= val_in;
      cur_ff     <= cur_in;
      end_ff     <= end_in;
      padr_ff    <= padr_in;
      ok_ff      <= ok_in;
      data_ff    <= data_in;
      found_ff   <= found_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pos_idx_in  = pos_idx_ff;
      val_in      = val_ff;
      len_in      = len_ff;
      cur_in      = cur_ff;
      end_in      = end_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      padr_in     = padr_ff;
      ok_in       = ok_ff;
      data_in     = data_ff;
      found_in    = found_ff;
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = padr_ff;
      ram_wr_data = ram_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = func_type'(req_func);
               pos_idx_in = AW'(pos_w - CW'(1));
               val_in     = req_value;
               ok_in      = 1'b0;
               data_in    = '0;
               found_in   = '0;
               iss_in     = 1'b1;
               pend_in    = 1'b0;
               state_in   = ST_DONE;
               unique case (func_type'(req_func))
                  FUNC_INSERT: begin
                     if (ins_ok) begin
                        ok_in  = 1'b1;
                        cur_in = AW'(len_w - CW'(1));
                        end_in = AW'(pos_w - CW'(1));
                        // Appending at the tail needs no shift.
                        state_in = (pos_w == len_w + CW'(1)) ? ST_PUT : ST_SHIFT;
                     end
                  end
                  FUNC_DELETE: begin
                     if (acc_ok) begin
                        ok_in    = 1'b1;
                        cur_in   = AW'(pos_w - CW'(1));
                        end_in   = AW'(len_w - CW'(1));
                        state_in = ST_SHIFT;
                     end
                  end
                  FUNC_READ: begin
                     if (acc_ok) begin
                        ok_in    = 1'b1;
                        cur_in   = AW'(pos_w - CW'(1));
                        end_in   = AW'(pos_w - CW'(1));
                        state_in = ST_SHIFT;
                     end
                  end
                  FUNC_LOCATE: begin
                     ok_in = 1'b1;
                     if (len_ff != '0) begin
                        cur_in   = '0;
                        end_in   = AW'(len_w - CW'(1));
                        state_in = ST_SHIFT;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_SHIFT: begin
            // A read is issued at cur_ff; its data returns in the following cycle and
            // is consumed while the next read is already in flight.
            if (iss_ff) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               padr_in   = cur_ff;
               if (cur_ff == end_ff) begin
                  iss_in = 1'b0;
               end else if (op_ff == FUNC_INSERT) begin
                  cur_in = cur_ff - AW'(1);
               end else begin
                  cur_in = cur_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
            end

            if (pend_ff) begin
               case (op_ff)
                  FUNC_INSERT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = padr_ff + AW'(1);
                  end
                  FUNC_DELETE: begin
                     // The first fetch is the removed byte; the rest move down.
                     if (padr_ff == pos_idx_ff) begin
                        data_in = ram_rd_data;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = padr_ff - AW'(1);
                     end
                  end
                  FUNC_READ: data_in = ram_rd_data;
                  default: begin
                     if (ram_rd_data == val_ff) begin
                        found_in = POS_W'({1'b0, padr_ff} + {{AW{1'b0}}, 1'b1});
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end

            if (!iss_ff) begin
               if (op_ff == FUNC_INSERT) begin
                  state_in = ST_PUT;
               end else begin
                  state_in = ST_DONE;
               end
               if (op_ff == FUNC_DELETE) begin
                  len_in = len_ff - LW'(1);
               end
            end
         end

         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_idx_ff;
            ram_wr_data = val_ff;
            len_in      = len_ff + LW'(1);
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      result.done     = (state_ff == ST_DONE) && rsp_free;
      result.ok       = ok_ff;
      result.data_out = data_ff;
      result.found_at = found_ff;
      result.count    = COUNT_W'(len_ff);
      result.is_empty = (len_ff == '0);
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("element store written while sequencer idle");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(DEPTH))
      else $error("list length exceeds store depth");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |=> (len_ff == $past(len_ff) + LW'(1)))
      else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

// ===== test/tb_positional_array_list.sv =====
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives insert, delete, read and locate requests through the valid/ready
// request channel and checks every response against a behavioral copy of the
// list. A directed opening covers the empty list, out-of-range positions and
// the list ends. Random rounds then alternate between filling the list to
// capacity and draining it, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_array_list;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int ROUNDS       = 6;
   localparam int ROUND_ITEMS  = 250;
   localparam int QUIET_ITEMS  = 200;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] data_out;
      logic [POS_W-1:0]   found_at;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } list_answer_type;

   class list_scoreboard;
      logic [VALUE_W-1:0] elements [DEPTH_DEF];
      int                 length;
      list_answer_type    expected_answers [$];
      int unsigned        errors, answers, refused, full_refusals;
      int unsigned        locate_hits, locate_misses, peak_length;
      int unsigned        op_count [4];

      function void apply_request(func_type func, logic [POS_W-1:0] position,
                                  logic [VALUE_W-1:0] value);
         list_answer_type ans;
         int              pos;
         int              k;
         ans = '0;
         pos = position;
         op_count[func]++;
         case (func)
            FUNC_INSERT: begin
               if (length == DEPTH_DEF) begin
                  full_refusals++;
               end
               if (pos >= 1 && pos <= length + 1 && length < DEPTH_DEF) begin
                  for (k = length; k >= pos; k--) begin
                     elements[k] = elements[k-1];
                  end
                  elements[pos-1] = value;
                  length++;
                  ans.ok = 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (pos >= 1 && pos <= length) begin
                  ans.data_out = elements[pos-1];
                  for (k = pos - 1; k + 1 < length; k++) begin
                     elements[k] = elements[k+1];
                  end
                  length--;
                  ans.ok = 1'b1;
               end
            end
            FUNC_READ: begin
               if (pos >= 1 && pos <= length) begin
                  ans.data_out = elements[pos-1];
                  ans.ok       = 1'b1;
               end
            end
            default: begin
               ans.ok = 1'b1;
               for (k = 0; k < length; k++) begin
                  if (elements[k] == value) begin
                     ans.found_at = POS_W'(k + 1);
                     break;
                  end
               end
               if (ans.found_at != 0) begin
                  locate_hits++;
               end else begin
                  locate_misses++;
               end
            end
         endcase
         if (!ans.ok) begin
            refused++;
         end
         if (length > peak_length) begin
            peak_length = length;
         end
         ans.count    = COUNT_W'(length);
         ans.is_empty = (length == 0);
         expected_answers.push_back(ans);
      endfunction

      function void check_answer(logic ok, logic [VALUE_W-1:0] data_out,
                                 logic [POS_W-1:0] found_at, logic [COUNT_W-1:0] count,
                                 logic is_empty);
         list_answer_type want;
         if (expected_answers.size() == 0) begin
            $error("response transaction arrived with no request outstanding");
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         answers++;
         if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            errors++;
         end
         if (data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, data_out);
            errors++;
         end
         if (found_at !== want.found_at) begin
            $error("found_at: expected %0d, got %0d", want.found_at, found_at);
            errors++;
         end
         if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            errors++;
         end
         if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   func_type           req_func = FUNC_INSERT;
   logic [POS_W-1:0]   req_position = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [VALUE_W-1:0] rsp_data_out;
   logic [POS_W-1:0]   rsp_found_at;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_is_empty;

   bit                 quiet = 1'b0;
   bit                 hold_off = 1'b0;
   int unsigned        hold_offs_done = 0;
   int                 stall_cycles = 0;
   list_scoreboard     sb;

   always #2 clock = ~clock;

   positional_array_list u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ok       (rsp_ok),
      .rsp_data_out (rsp_data_out),
      .rsp_found_at (rsp_found_at),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   // Offers one request, with an optional idle burst first, and returns at the
   // edge where it is accepted. Valid stays high so the next call can follow
   // back to back.
   task automatic send_request(input func_type func, input int position, input int value);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_func     <= func;
      req_position <= position[POS_W-1:0];
      req_value    <= value[VALUE_W-1:0];
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(func, position[POS_W-1:0], value[VALUE_W-1:0]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_answer(rsp_ok, rsp_data_out, rsp_found_at, rsp_count, rsp_is_empty);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Response side: random ready bursts, and one long hold-off on request so
   // that the block backs up and stalls the request channel.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            hold_off  <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_offs_done++;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24) - 1) @(posedge clock);
         end
      end
   end

   initial begin
      func_type func;
      int       round;
      int       item;
      int       roll;
      int       len;
      int       lim;
      int       pos;
      int       val;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty list: everything positional fails, locate misses.
      send_request(FUNC_READ,   1,   8'h00);
      send_request(FUNC_DELETE, 1,   8'h00);
      send_request(FUNC_LOCATE, 0,   8'h00);
      send_request(FUNC_INSERT, 0,   8'h11);
      send_request(FUNC_INSERT, 2,   8'h11);
      // Build a short list at the end, the front and the middle.
      send_request(FUNC_INSERT, 1,   8'hFF);
      send_request(FUNC_INSERT, 1,   8'h00);
      send_request(FUNC_INSERT, 3,   8'hA5);
      send_request(FUNC_INSERT, 2,   8'h5A);
      send_request(FUNC_INSERT, 2,   8'hA5);
      send_request(FUNC_INSERT, 7,   8'h77);
      send_request(FUNC_INSERT, 127, 8'h77);
      send_request(FUNC_READ,   0,   8'h00);
      send_request(FUNC_READ,   5,   8'h00);
      send_request(FUNC_READ,   6,   8'h00);
      send_request(FUNC_READ,   127, 8'hFF);
      // Duplicate value: locate must report the first one.
      send_request(FUNC_LOCATE, 127, 8'hA5);
      send_request(FUNC_LOCATE, 64,  8'hFF);
      send_request(FUNC_LOCATE, 1,   8'h11);
      send_request(FUNC_DELETE, 5,   8'h00);
      send_request(FUNC_DELETE, 1,   8'h00);
      send_request(FUNC_DELETE, 2,   8'h00);
      send_request(FUNC_DELETE, 127, 8'h00);
      send_request(FUNC_DELETE, 0,   8'h00);

      // Even rounds lean toward inserts and run into the full list, odd
      // rounds lean toward deletes and drain it.
      for (round = 0; round < ROUNDS; round++) begin
         if (round == 1) begin
            hold_off <= 1'b1;
         end
         for (item = 0; item < ROUND_ITEMS; item++) begin
            if (round == ROUNDS - 1 && item == ROUND_ITEMS - QUIET_ITEMS) begin
               quiet = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (round % 2 == 0) begin
               func = roll < 50 ? FUNC_INSERT : roll < 65 ? FUNC_DELETE :
                      roll < 80 ? FUNC_READ : FUNC_LOCATE;
            end else begin
               func = roll < 15 ? FUNC_INSERT : roll < 65 ? FUNC_DELETE :
                      roll < 80 ? FUNC_READ : FUNC_LOCATE;
            end
            len  = sb.length;
            lim  = (func == FUNC_INSERT) ? len + 1 : len;
            roll = $urandom_range(0, 99);
            if (roll < 85 && lim >= 1) begin
               pos = $urandom_range(1, lim);
            end else if (roll < 95) begin
               pos = (roll % 2 == 0) ? 0 : lim + 1;
            end else begin
               pos = $urandom_range(0, 127);
            end
            roll = $urandom_range(0, 99);
            if (func == FUNC_LOCATE && len > 0 && roll < 60) begin
               val = sb.elements[$urandom_range(0, len - 1)];
            end else if (roll < 80) begin
               val = $urandom_range(0, 255);
            end else begin
               // A narrow set of values makes duplicates common.
               val = $urandom_range(0, 3);
            end
            send_request(func, pos, val);
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Ran %0d transactions: %0d insert, %0d delete, %0d read, %0d locate, %0d refused.",
               sb.answers, sb.op_count[FUNC_INSERT], sb.op_count[FUNC_DELETE],
               sb.op_count[FUNC_READ], sb.op_count[FUNC_LOCATE], sb.refused);
      $display("Peak length %0d, %0d full inserts, locate %0d hit %0d miss, %0d hold-offs.",
               sb.peak_length, sb.full_refusals, sb.locate_hits, sb.locate_misses,
               hold_offs_done);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/pal_ctrl.sv
rtl/positional_array_list.sv
test/tb_positional_array_list.sv
